// ----- rtl/core/ppb_pkg.sv -----
package ppb_pkg;

   localparam int unsigned POS_W  = 32;
   localparam int unsigned DT_W   = 16;
   localparam int unsigned NRM_W  = 18;
   localparam int unsigned OFF_W  = 32;
   localparam int unsigned RST_W  = 17;
   localparam int unsigned FRC_W  = 21;
   localparam int unsigned CSR_W  = 32;
   localparam int unsigned IDX_W  = 3;

   localparam logic [IDX_W-1:0] CSR_NRM_X = 3'd0;
   localparam logic [IDX_W-1:0] CSR_NRM_Y = 3'd1;
   localparam logic [IDX_W-1:0] CSR_NRM_Z = 3'd2;
   localparam logic [IDX_W-1:0] CSR_OFF   = 3'd3;
   localparam logic [IDX_W-1:0] CSR_REST  = 3'd4;
   localparam logic [IDX_W-1:0] CSR_FRIC  = 3'd5;

   localparam logic signed [63:0] EPS_Q32 = 64'sd429496730;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] grav_x;
      logic signed [31:0] grav_y;
      logic signed [31:0] grav_z;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               bounced;
   } rsp_type;

   typedef struct packed {
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic signed [17:0] nz;
      logic signed [31:0] off;
      logic [16:0]        rest;
      logic [20:0]        fric;
   } cfg_type;

   function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
      logic signed [63:0] t;
      t = x + 64'sd32768;
      return t >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

endpackage

// ----- rtl/core/ppb_stream_if.sv -----
interface ppb_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/particle_plane_bounce_step.sv -----
// One Euler step of a particle against one plane, Q16.16, one word per clock
// sustained while the rsp side does not stall. There are nine register stages
// from req acceptance to the rsp register. Every stage but the last holds one or
// two multiplies per axis, the widest 20x35 bits (k times the rounded v dot);
// plane dots are split into per-axis products then summed. The pipeline advances
// whenever its last stage is empty or being taken, so stalls lose nothing. Plane
// registers are read live by the stages, so they are to be written only while
// the block is idle; that is a rule on the user, the block does not enforce it.
module particle_plane_bounce_step
   import ppb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ppb_stream_if.sink             req,
   ppb_stream_if.source           rsp,
   input  logic                   csr_we,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

   localparam int unsigned NST = 9;

   typedef logic signed [17:0] s18_type;
   typedef logic signed [19:0] s20_type;
   typedef logic signed [31:0] s32_type;
   typedef logic signed [63:0] s64_type;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nx   <= '0;
         cfg_ff.ny   <= 18'sd65536;
         cfg_ff.nz   <= '0;
         cfg_ff.off  <= '0;
         cfg_ff.rest <= '0;
         cfg_ff.fric <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NRM_X: cfg_ff.nx   <= csr_data[NRM_W-1:0];
            CSR_NRM_Y: cfg_ff.ny   <= csr_data[NRM_W-1:0];
            CSR_NRM_Z: cfg_ff.nz   <= csr_data[NRM_W-1:0];
            CSR_OFF:   cfg_ff.off  <= csr_data[OFF_W-1:0];
            CSR_REST:  cfg_ff.rest <= csr_data[RST_W-1:0];
            CSR_FRIC:  cfg_ff.fric <= csr_data[FRC_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline word
   typedef struct packed {
      s32_type [2:0]      p;
      s32_type [2:0]      v;
      s32_type [2:0]      g;
      logic [15:0]        dt;
      s64_type [2:0]      t;    // per-lane scratch products
      logic signed [63:0] dot;
      s20_type [2:0]      k;
      logic               grav;
      logic               hit;
   } pw_type;

   pw_type s_ff [NST];
   pw_type s_in [NST];
   logic [NST-1:0] v_ff;
   logic           adv;

   assign adv       = !v_ff[NST-1] || rsp.ready;
   assign req.ready = adv;

   s18_type [2:0] n;
   assign n[0] = cfg_ff.nx;
   assign n[1] = cfg_ff.ny;
   assign n[2] = cfg_ff.nz;

   always_comb begin
      logic signed [63:0] off32, d, dv, a;
      off32 = 64'(cfg_ff.off) <<< 16;
      s_in[0] = '0;
      for (int s = 1; s < NST; s++) s_in[s] = s_ff[s-1];
      // stage 0: n*p per axis, k per axis
      s_in[0].dt = req.data.time_step;
      s_in[0].p[0] = req.data.pos_x; s_in[0].p[1] = req.data.pos_y;
      s_in[0].p[2] = req.data.pos_z;
      s_in[0].v[0] = req.data.vel_x; s_in[0].v[1] = req.data.vel_y;
      s_in[0].v[2] = req.data.vel_z;
      s_in[0].g[0] = req.data.grav_x; s_in[0].g[1] = req.data.grav_y;
      s_in[0].g[2] = req.data.grav_z;
      for (int i = 0; i < 3; i++) begin
         s_in[0].k[i] = 20'(rnd16(64'($signed({1'b0, 17'(cfg_ff.rest)})
                        + 64'sd65536) * 64'(n[i])));
      end
      s_in[0].t[0] = 64'(n[0]) * 64'(req.data.pos_x);
      s_in[0].t[1] = 64'(n[1]) * 64'(req.data.pos_y);
      s_in[0].t[2] = 64'(n[2]) * 64'(req.data.pos_z);
      // stage 1: dot p, flags, gravity product
      s_in[1].dot  = s_ff[0].t[0] + s_ff[0].t[1] + s_ff[0].t[2];
      s_in[1].hit  = s_in[1].dot < off32;
      s_in[1].grav = !(s_in[1].dot < off32 + EPS_Q32);
      for (int i = 0; i < 3; i++)
         s_in[1].t[i] = 64'(s_ff[0].g[i]) * 64'($signed({1'b0, s_ff[0].dt}));
      // stage 2: gravity add; push product
      d = rnd16(s_ff[1].dot - off32);
      for (int i = 0; i < 3; i++) begin
         if (s_ff[1].grav)
            s_in[2].v[i] = sat32(64'(s_ff[1].v[i]) + rnd16(s_ff[1].t[i]));
         s_in[2].t[i] = d * 64'(n[i]);
      end
      // stage 3: push; n*v products
      for (int i = 0; i < 3; i++) begin
         if (s_ff[2].hit)
            s_in[3].p[i] = sat32(64'(s_ff[2].p[i]) - rnd16(s_ff[2].t[i]));
         s_in[3].t[i] = 64'(n[i]) * 64'(s_ff[2].v[i]);
      end
      // stage 4: dot v, k*dv products
      dv = rnd16(s_ff[3].t[0] + s_ff[3].t[1] + s_ff[3].t[2]);
      for (int i = 0; i < 3; i++) s_in[4].t[i] = 64'(s_ff[3].k[i]) * dv;
      // stage 5: reflect; friction product
      for (int i = 0; i < 3; i++) begin
         a = 64'(s_ff[4].v[i]);
         if (s_ff[4].hit) a = 64'(sat32(a - rnd16(s_ff[4].t[i])));
         s_in[5].v[i] = a[31:0];
         s_in[5].t[i] = a * 64'($signed({1'b0, cfg_ff.fric}));
      end
      // stage 6: f*dt
      for (int i = 0; i < 3; i++)
         s_in[6].t[i] = rnd16(s_ff[5].t[i]) * 64'($signed({1'b0, s_ff[5].dt}));
      // stage 7: friction sub; v*dt
      for (int i = 0; i < 3; i++) begin
         a = 64'(sat32(64'(s_ff[6].v[i]) - rnd16(s_ff[6].t[i])));
         s_in[7].v[i] = a[31:0];
         s_in[7].t[i] = a * 64'($signed({1'b0, s_ff[6].dt}));
      end
      // stage 8: integrate
      for (int i = 0; i < 3; i++)
         s_in[8].p[i] = sat32(64'(s_ff[7].p[i]) + rnd16(s_ff[7].t[i]));
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NST-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (adv) for (int s = 0; s < NST; s++) s_ff[s] <= s_in[s];
   end

   assign rsp.valid = v_ff[NST-1];
   assign rsp.data.new_pos_x = s_ff[NST-1].p[0];
   assign rsp.data.new_pos_y = s_ff[NST-1].p[1];
   assign rsp.data.new_pos_z = s_ff[NST-1].p[2];
   assign rsp.data.new_vel_x = s_ff[NST-1].v[0];
   assign rsp.data.new_vel_y = s_ff[NST-1].v[1];
   assign rsp.data.new_vel_z = s_ff[NST-1].v[2];
   assign rsp.data.bounced   = s_ff[NST-1].hit;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("rsp word changed under stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(v_ff))
      else $error("pipeline moved under stall");
   a_bnc: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] && s_ff[1].hit |-> !s_ff[1].grav)
      else $error("gravity applied on a hit");

endmodule

// ----- dv/ppb_checker.sv -----
module ppb_checker
   import ppb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_data,
   output int          errors,
   output int          pending,
   output logic        progress
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [63:0] ONE_Q16 = 64'sd65536;
   localparam logic signed [63:0] NEAR_EPS = 64'sd429496730;

   cfg_type plane;
   rsp_type step_q[$];

   function automatic logic signed [63:0] round_q16(input logic signed [63:0] x);
      logic signed [63:0] t;
      t = x + 64'sd32768;
      return t >>> 16;
   endfunction

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic rsp_type advance(input req_type r, input cfg_type c);
      logic signed [63:0] p[3], v[3], g[3], n[3];
      logic signed [63:0] dt, off32, dotp, dotv, d, dv, k, f;
      rsp_type o;
      p[0] = r.pos_x; p[1] = r.pos_y; p[2] = r.pos_z;
      v[0] = r.vel_x; v[1] = r.vel_y; v[2] = r.vel_z;
      g[0] = r.grav_x; g[1] = r.grav_y; g[2] = r.grav_z;
      n[0] = c.nx; n[1] = c.ny; n[2] = c.nz;
      dt = $signed({48'd0, r.time_step});
      off32 = 64'(c.off) * ONE_Q16;
      dotp = n[0] * p[0] + n[1] * p[1] + n[2] * p[2];
      o.bounced = 1'b0;
      if (!(dotp < off32 + NEAR_EPS))
         for (int i = 0; i < 3; i++) v[i] = clamp32(v[i] + round_q16(g[i] * dt));
      if (dotp < off32) begin
         o.bounced = 1'b1;
         dotv = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
         d = round_q16(dotp - off32);
         dv = round_q16(dotv);
         for (int i = 0; i < 3; i++) begin
            k = round_q16((ONE_Q16 + $signed({47'd0, c.rest})) * n[i]);
            p[i] = clamp32(p[i] - round_q16(d * n[i]));
            v[i] = clamp32(v[i] - round_q16(k * dv));
         end
      end
      for (int i = 0; i < 3; i++) begin
         f = round_q16(v[i] * $signed({43'd0, c.fric}));
         v[i] = clamp32(v[i] - round_q16(f * dt));
      end
      for (int i = 0; i < 3; i++) p[i] = clamp32(p[i] + round_q16(v[i] * dt));
      o.new_pos_x = p[0][31:0]; o.new_pos_y = p[1][31:0]; o.new_pos_z = p[2][31:0];
      o.new_vel_x = v[0][31:0]; o.new_vel_y = v[1][31:0]; o.new_vel_z = v[2][31:0];
      return o;
   endfunction

   task automatic compare(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $error("%s expected %h actual %h", name, e, a);
         errors++;
      end
   endtask

   assign pending = step_q.size();
   assign progress = (req_valid && req_ready) || (rsp_valid && rsp_ready);

   initial errors = 0;

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         plane <= '{nx: '0, ny: 18'sd65536, nz: '0, off: '0, rest: '0, fric: '0};
         step_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NRM_X: plane.nx <= csr_data[17:0];
               CSR_NRM_Y: plane.ny <= csr_data[17:0];
               CSR_NRM_Z: plane.nz <= csr_data[17:0];
               CSR_OFF:   plane.off <= csr_data;
               CSR_REST:  plane.rest <= csr_data[16:0];
               CSR_FRIC:  plane.fric <= csr_data[20:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) step_q.push_back(advance(req_data, plane));
         if (rsp_valid && rsp_ready) begin
            if (step_q.size() == 0) begin
               $error("unexpected result word");
               errors++;
            end else begin
               e = step_q.pop_front();
               compare("new_pos_x", e.new_pos_x, rsp_data.new_pos_x);
               compare("new_pos_y", e.new_pos_y, rsp_data.new_pos_y);
               compare("new_pos_z", e.new_pos_z, rsp_data.new_pos_z);
               compare("new_vel_x", e.new_vel_x, rsp_data.new_vel_x);
               compare("new_vel_y", e.new_vel_y, rsp_data.new_vel_y);
               compare("new_vel_z", e.new_vel_z, rsp_data.new_vel_z);
               compare("bounced", 32'(e.bounced), 32'(rsp_data.bounced));
            end
         end
      end
   end
endmodule

// ----- dv/particle_plane_bounce_step_tb.sv -----
module particle_plane_bounce_step_tb;
   import ppb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 5000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_data;
   int errors, pending, idle_cycles;
   logic progress;
   bit hold_long;

   ppb_stream_if #(.payload_type(req_type)) req_if ();
   ppb_stream_if #(.payload_type(rsp_type)) rsp_if ();

   particle_plane_bounce_step DUT (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   ppb_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_data(req_if.data),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_data(rsp_if.data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending), .progress(progress)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset = 1'b1;
      hold_long = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || !progress) idle_cycles <= reset ? 0 : idle_cycles + 1;
      else idle_cycles <= 0;
      if (idle_cycles > WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stall pattern
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_if.ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_long = 1'b0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(1, 40)) begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] rand_field(input int near);
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return $signed($urandom_range(0, 2 * near)) - near;
      endcase
   endfunction

   function automatic req_type rand_particle();
      req_type r;
      r.pos_x = rand_field(20 << 16);
      r.pos_y = rand_field(2 << 16);
      r.pos_z = rand_field(20 << 16);
      r.vel_x = rand_field(50 << 16);
      r.vel_y = rand_field(50 << 16);
      r.vel_z = rand_field(50 << 16);
      r.grav_x = rand_field(10 << 16);
      r.grav_y = rand_field(10 << 16);
      r.grav_z = rand_field(10 << 16);
      r.time_step = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      return r;
   endfunction

   task automatic send(input req_type r);
      req_if.valid <= 1'b1;
      req_if.data <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic burst_items(input int count);
      int left;
      left = count;
      while (left > 0) begin
         repeat ($urandom_range(1, 30)) begin
            if (left > 0) begin
               send(rand_particle());
               left--;
            end
         end
         if ($urandom_range(0, 2) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   initial begin
      req_type r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed at reset settings: above, near band, below, extremes
      r = '0; r.time_step = 16'hffff; r.pos_y = 32'sh00010000; r.grav_y = -32'sd642252;
      send(r);
      r.pos_y = 32'sd3000; send(r);
      r.pos_y = -32'sd100000; r.vel_y = -32'sd500000; send(r);
      r.pos_y = 32'sh80000000; r.vel_y = 32'sh80000000; send(r);
      r = '{default: 32'sh7fffffff, time_step: 16'hffff}; send(r);
      r = '{default: 32'sh80000000, time_step: 16'hffff}; send(r);
      r = '{default: 32'sh80000000, time_step: 16'h0000}; send(r);
      drain();

      // extreme settings
      write_reg(CSR_NRM_X, 32'h0001ffff);
      write_reg(CSR_NRM_Y, 32'h00020000);
      write_reg(CSR_NRM_Z, 32'h00010000);
      write_reg(CSR_OFF, 32'h7fffffff);
      write_reg(CSR_REST, 32'h0001ffff);
      write_reg(CSR_FRIC, 32'h001fffff);
      write_reg(3'd7, 32'hffffffff);
      for (int i = 0; i < 8; i++) send(rand_particle());
      r = '{default: 32'sh7fffffff, time_step: 16'hffff}; send(r);
      r = '{default: 32'sh80000000, time_step: 16'hffff}; send(r);
      drain();
      write_reg(CSR_OFF, 32'h80000000);
      write_reg(CSR_REST, 32'h00000000);
      for (int i = 0; i < 6; i++) send(rand_particle());
      drain();

      // random phases with fresh settings
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_NRM_X, ph[0] ? 32'($urandom) : 32'd0);
         write_reg(CSR_NRM_Y, ph < 2 ? 32'h00010000 : 32'($urandom));
         write_reg(CSR_NRM_Z, ph[1] ? 32'($urandom) : 32'd0);
         write_reg(CSR_OFF, ph[2] ? 32'($urandom) : 32'($signed($urandom_range(0, 65536)) - 32768));
         write_reg(CSR_REST, ph == 3 ? 32'h00010000 : 32'($urandom));
         write_reg(CSR_FRIC, ph == 5 ? 32'h00100000 : 32'($urandom_range(0, 200000)));
         if (ph == 4) hold_long = 1'b1;
         burst_items(250);
         drain();
      end

      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
